// File: hw/rtl/rfd_pkg.sv
// Shared types and constants of the RPC frame deframer.
package rfd_pkg;

  // Width of the configuration register index and data.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgAddrW-1:0] CfgIdxStartByte   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgIdxEndByte     = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgIdxMaxFrameLen = 2'd2;

  // Register values after reset.
  localparam logic [7:0]  StartByteRst   = 8'h02;
  localparam logic [7:0]  EndByteRst     = 8'h03;
  localparam logic [23:0] MaxFrameLenRst = 24'h010000;

  // Bytes of a frame that are not text or payload: start, length, three text
  // lengths, error code, checksum and end.
  localparam logic [23:0] FixedOverhead = 24'd26;

  // Width of the packed result on the output stream.
  localparam int unsigned TdataW = 168;
  localparam int unsigned TuserW = 3;

  typedef enum logic [3:0] {
    PhHunt   = 4'd0,
    PhFlen   = 4'd1,
    PhRidLen = 4'd2,
    PhRid    = 4'd3,
    PhMnLen  = 4'd4,
    PhMn     = 4'd5,
    PhErrc   = 4'd6,
    PhEtLen  = 4'd7,
    PhEt     = 4'd8,
    PhPay    = 4'd9,
    PhCks    = 4'd10,
    PhSkip   = 4'd11
  } rfd_phase_e;

  typedef enum logic {
    KindContent = 1'b0,
    KindSummary = 1'b1
  } rfd_kind_e;

  typedef enum logic [1:0] {
    TagRequestId  = 2'd0,
    TagMethodName = 2'd1,
    TagErrorText  = 2'd2,
    TagPayload    = 2'd3
  } rfd_tag_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadEnd   = 2'd1,
    StatusOverrun  = 2'd2,
    StatusBadLen   = 2'd3
  } rfd_status_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [23:0] max_frame_len;
  } rfd_cfg_t;

  typedef struct packed {
    logic signed [31:0] error_value;
    logic [23:0]        payload_length;
    logic [23:0]        error_text_length;
    logic [23:0]        method_name_length;
    logic [23:0]        request_id_length;
    logic [23:0]        frame_length;
    rfd_status_e        status;
    logic [7:0]         data_byte;
    rfd_tag_e           field_tag;
    rfd_kind_e          result_kind;
  } rfd_result_t;

endpackage

// File: hw/rtl/rpc_frame_deframer_core.sv
// Top level of the RPC frame deframer: input register, settings and output stream.
//
// The deframer takes one received byte per transfer on the slave stream and
// hunts for the start byte. After it, a 4-byte big-endian frame length is read
// and the frame layout is walked: request-id length and bytes, method-name
// length and bytes, a 4-byte error code, error-text length and bytes, the
// payload, 4 checksum bytes that are dropped, and the end byte at frame length
// minus one (the start byte is position zero). Every text and payload byte
// leaves as a content result with its field tag, and the last frame position
// produces a summary with the lengths, the error code and a status: ok, bad
// end byte, field overrun or bad frame length. A frame length below 26 or
// above max_frame_len is rejected with a summary as soon as it is complete.
// After any summary, hunting resumes at the very next byte. The block
// sustains one byte per clock cycle while the result queue has room: the
// only loop is the field state machine, which advances once per byte. A
// byte is parsed straight out of the input register, and its result is
// written into the result queue and offered on the master stream from
// there. A two-entry result queue lets the input keep flowing while a
// result waits; input stalls only once that queue is full. The user must
// write settings through the plain write port only while no byte is in
// flight; the block itself does not enforce this.
module rpc_frame_deframer_core #(
  parameter int unsigned LengthBits = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [rfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Received byte stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] data_byte, [9:8] status, [33:10] frame_length,
  // [57:34] request_id_length, [81:58] method_name_length,
  // [105:82] error_text_length, [129:106] payload_length,
  // [161:130] error_value, [167:162] zero
  output logic [rfd_pkg::TdataW-1:0]  m_axis_tdata,
  // [0] result_kind, [2:1] field_tag
  output logic [rfd_pkg::TuserW-1:0]  m_axis_tuser
);
  import rfd_pkg::*;

  rfd_cfg_t    cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        step;
  logic        fifo_full;
  logic        res_valid;
  rfd_result_t res;
  rfd_result_t out_res;

  // A held byte is parsed once the result queue has room; the input register
  // refills in the same cycle.
  assign step          = in_valid_q && !fifo_full;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  // Settings registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= StartByteRst;
      cfg_q.end_byte      <= EndByteRst;
      cfg_q.max_frame_len <= MaxFrameLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgIdxStartByte:   cfg_q.start_byte    <= cfg_wdata_i[7:0];
        CfgIdxEndByte:     cfg_q.end_byte      <= cfg_wdata_i[7:0];
        CfgIdxMaxFrameLen: cfg_q.max_frame_len <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  rfd_parser #(
    .LengthBits(LengthBits)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  rfd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (fifo_full),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (out_res)
  );

  assign m_axis_tdata = {6'b0,
                         out_res.error_value,
                         out_res.payload_length,
                         out_res.error_text_length,
                         out_res.method_name_length,
                         out_res.request_id_length,
                         out_res.frame_length,
                         out_res.status,
                         out_res.data_byte};
  assign m_axis_tuser = {out_res.field_tag, out_res.result_kind};

endmodule

// File: hw/rtl/rfd_parser.sv
// Frame layout state machine: takes one byte per step and forms at most one result.
module rfd_parser #(
  parameter int unsigned LengthBits = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  rfd_pkg::rfd_cfg_t    cfg_i,
  output logic                 res_valid_o,
  output rfd_pkg::rfd_result_t res_o
);
  import rfd_pkg::*;

  // Largest length that the link format can carry.
  localparam logic [31:0] LenMax = 32'((64'(1) << LengthBits) - 64'(1));

  rfd_phase_e  phase_q, phase_d;
  logic [23:0] pos_q, pos_d;
  logic [23:0] remain_q, remain_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  wcnt_q, wcnt_d;
  logic [23:0] rid_len_q, rid_len_d;
  logic [23:0] mn_len_q, mn_len_d;
  logic [23:0] et_len_q, et_len_d;
  logic [23:0] pay_len_q, pay_len_d;
  logic [31:0] err_q, err_d;
  logic        overrun_q, overrun_d;
  logic [23:0] flen_q, flen_d;
  logic [23:0] budget_q, budget_d;

  logic [31:0] word_nxt;
  logic [31:0] word_sat;
  logic        word_done;
  logic        at_end;
  logic        flen_bad;
  logic        len_over;
  logic [23:0] budget_left;
  logic        last_byte;
  logic        is_start;

  assign word_nxt    = {word_q[23:0], byte_i};
  assign word_done   = (wcnt_q == 2'd3);
  assign word_sat    = (word_nxt > LenMax) ? LenMax : word_nxt;
  assign at_end      = (pos_q == (flen_q - 24'd1));
  assign flen_bad    = (word_nxt < {8'b0, FixedOverhead}) ||
                       (word_nxt > {8'b0, cfg_i.max_frame_len}) ||
                       (word_nxt > LenMax);
  assign len_over    = (word_nxt > {8'b0, budget_q});
  assign budget_left = budget_q - word_nxt[23:0];
  assign last_byte   = (remain_q == 24'd1);
  assign is_start    = (byte_i == cfg_i.start_byte);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q) inside
        PhFlen: begin
          if (word_done) phase_d = flen_bad ? PhHunt : PhRidLen;
        end
        PhRidLen: begin
          if (at_end) phase_d = PhHunt;
          else if (word_done) begin
            phase_d = len_over ? PhSkip : ((word_nxt != '0) ? PhRid : PhMnLen);
          end
        end
        PhRid: begin
          if (at_end) phase_d = PhHunt;
          else if (last_byte) phase_d = PhMnLen;
        end
        PhMnLen: begin
          if (at_end) phase_d = PhHunt;
          else if (word_done) begin
            phase_d = len_over ? PhSkip : ((word_nxt != '0) ? PhMn : PhErrc);
          end
        end
        PhMn: begin
          if (at_end) phase_d = PhHunt;
          else if (last_byte) phase_d = PhErrc;
        end
        PhErrc: begin
          if (at_end) phase_d = PhHunt;
          else if (word_done) phase_d = PhEtLen;
        end
        PhEtLen: begin
          if (at_end) phase_d = PhHunt;
          else if (word_done) begin
            if (len_over) phase_d = PhSkip;
            else if (word_nxt != '0) phase_d = PhEt;
            else if (budget_left != '0) phase_d = PhPay;
            else phase_d = PhCks;
          end
        end
        PhEt: begin
          if (at_end) phase_d = PhHunt;
          else if (last_byte) phase_d = (pay_len_q != '0) ? PhPay : PhCks;
        end
        PhPay: begin
          if (at_end) phase_d = PhHunt;
          else if (last_byte) phase_d = PhCks;
        end
        PhCks, PhSkip: begin
          if (at_end) phase_d = PhHunt;
        end
        default: phase_d = is_start ? PhFlen : PhHunt;
      endcase
    end
  end

  // Counters, captured fields and the result.
  always_comb begin
    pos_d       = pos_q;
    remain_d    = remain_q;
    word_d      = word_q;
    wcnt_d      = wcnt_q;
    rid_len_d   = rid_len_q;
    mn_len_d    = mn_len_q;
    et_len_d    = et_len_q;
    pay_len_d   = pay_len_q;
    err_d       = err_q;
    overrun_d   = overrun_q;
    flen_d      = flen_q;
    budget_d    = budget_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // Summary fields come from the captured values; the status is set below.
    res_o.result_kind        = KindContent;
    res_o.request_id_length  = '0;

    if (step_i) begin
      if (phase_q == PhHunt || phase_q > PhSkip) begin
        if (is_start) begin
          pos_d     = 24'd1;
          remain_d  = '0;
          word_d    = '0;
          wcnt_d    = '0;
          rid_len_d = '0;
          mn_len_d  = '0;
          et_len_d  = '0;
          pay_len_d = '0;
          err_d     = '0;
          overrun_d = 1'b0;
          flen_d    = '0;
        end
      end else if (phase_q == PhFlen) begin
        pos_d  = pos_q + 24'd1;
        word_d = word_nxt;
        wcnt_d = word_done ? 2'd0 : wcnt_q + 2'd1;
        if (word_done) begin
          if (flen_bad) begin
            res_valid_o                    = 1'b1;
            res_o.result_kind              = KindSummary;
            res_o.status                   = StatusBadLen;
            res_o.frame_length             = word_sat[23:0];
            res_o.request_id_length        = rid_len_q;
            res_o.method_name_length       = mn_len_q;
            res_o.error_text_length        = et_len_q;
            res_o.payload_length           = pay_len_q;
            res_o.error_value              = err_q;
          end else begin
            flen_d   = word_nxt[23:0];
            budget_d = word_nxt[23:0] - FixedOverhead;
          end
        end
      end else begin
        pos_d = pos_q + 24'd1;
        if (at_end) begin
          res_valid_o              = 1'b1;
          res_o.result_kind        = KindSummary;
          res_o.status             = overrun_q ? StatusOverrun :
                                     ((byte_i == cfg_i.end_byte) ? StatusOk : StatusBadEnd);
          res_o.frame_length       = flen_q;
          res_o.request_id_length  = rid_len_q;
          res_o.method_name_length = mn_len_q;
          res_o.error_text_length  = et_len_q;
          res_o.payload_length     = pay_len_q;
          res_o.error_value        = err_q;
        end else begin
          case (phase_q) inside
            PhRidLen, PhMnLen, PhErrc, PhEtLen, PhCks: begin
              word_d = word_nxt;
              wcnt_d = word_done ? 2'd0 : wcnt_q + 2'd1;
            end
            default: ;
          endcase

          case (phase_q) inside
            PhRidLen, PhMnLen: begin
              if (word_done) begin
                if (phase_q == PhRidLen) rid_len_d = word_sat[23:0];
                else mn_len_d = word_sat[23:0];
                if (len_over) begin
                  overrun_d = 1'b1;
                end else begin
                  remain_d = word_nxt[23:0];
                  budget_d = budget_left;
                end
              end
            end
            PhErrc: begin
              if (word_done) err_d = word_nxt;
            end
            PhEtLen: begin
              if (word_done) begin
                et_len_d = word_sat[23:0];
                if (len_over) begin
                  overrun_d = 1'b1;
                end else begin
                  pay_len_d = budget_left;
                  remain_d  = (word_nxt != '0) ? word_nxt[23:0] : budget_left;
                end
              end
            end
            PhRid, PhMn, PhEt, PhPay: begin
              res_valid_o     = 1'b1;
              res_o.data_byte = byte_i;
              case (phase_q)
                PhRid:   res_o.field_tag = TagRequestId;
                PhMn:    res_o.field_tag = TagMethodName;
                PhEt:    res_o.field_tag = TagErrorText;
                default: res_o.field_tag = TagPayload;
              endcase
              // The error text hands over to the payload count when it ends.
              if (phase_q == PhEt && last_byte) remain_d = pay_len_q;
              else remain_d = remain_q - 24'd1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      pos_q     <= '0;
      remain_q  <= '0;
      word_q    <= '0;
      wcnt_q    <= '0;
      rid_len_q <= '0;
      mn_len_q  <= '0;
      et_len_q  <= '0;
      pay_len_q <= '0;
      err_q     <= '0;
      overrun_q <= 1'b0;
      flen_q    <= '0;
      budget_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      remain_q  <= remain_d;
      word_q    <= word_d;
      wcnt_q    <= wcnt_d;
      rid_len_q <= rid_len_d;
      mn_len_q  <= mn_len_d;
      et_len_q  <= et_len_d;
      pay_len_q <= pay_len_d;
      err_q     <= err_d;
      overrun_q <= overrun_d;
      flen_q    <= flen_d;
      budget_q  <= budget_d;
    end
  end

endmodule

// File: hw/rtl/rfd_out_fifo.sv
// Two-entry result queue that decouples the parser from the output stream.
module rfd_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rfd_pkg::rfd_result_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rfd_pkg::rfd_result_t data_o
);
  import rfd_pkg::*;

  rfd_result_t slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule
